[rtl/ehp_pkg.sv]
// ehp_pkg: shared types, constants and header tables of the ethernet header parser
package ehp_pkg;

  localparam int unsigned CountWidth   = 32;
  localparam int unsigned ArpAddrBytes = 8;
  localparam int unsigned MaxRecs      = 6;
  localparam int unsigned RecIdxW      = 3;

  localparam logic [15:0] ThresholdReset = 16'h05FE;
  localparam logic [15:0] RawPrefix      = 16'hFFFF;
  localparam logic [15:0] SnapPrefix     = 16'hAAAA;
  localparam logic [15:0] IpLlcPrefix    = 16'h0606;
  localparam logic [15:0] BpduPrefix     = 16'h4242;
  localparam logic [15:0] TypeIpv4       = 16'h0800;
  localparam logic [15:0] TypeArp        = 16'h0806;
  localparam logic [15:0] IpHdrBytes     = 16'd20;
  localparam logic [15:0] FlagsMask      = 16'hE000;
  localparam logic [15:0] FragMask       = 16'h1FFF;
  localparam logic [63:0] ArpMask        = {64{1'b1}} >> (64 - 8 * ArpAddrBytes);

  localparam logic [5:0] IdDst       = 6'd0;
  localparam logic [5:0] IdType      = 6'd2;
  localparam logic [5:0] IdLlcPair   = 6'd3;
  localparam logic [5:0] IdLlcCtrl   = 6'd4;
  localparam logic [5:0] IdSnapType  = 6'd6;
  localparam logic [5:0] IdIpVer     = 6'd7;
  localparam logic [5:0] IdIpHlen    = 6'd8;
  localparam logic [5:0] IdIpLen     = 6'd10;
  localparam logic [5:0] IdIpFlags   = 6'd12;
  localparam logic [5:0] IdIpFrag    = 6'd13;
  localparam logic [5:0] IdIpDst     = 6'd18;
  localparam logic [5:0] IdArpHlen   = 6'd21;
  localparam logic [5:0] IdArpPlen   = 6'd22;
  localparam logic [5:0] IdArpOp     = 6'd23;
  localparam logic [5:0] IdArpSha    = 6'd24;
  localparam logic [5:0] IdFwdDelay  = 6'd39;
  localparam logic [5:0] IdFrameCnt  = 6'd40;
  localparam logic [5:0] IdIpv4Cnt   = 6'd41;
  localparam logic [5:0] IdLlcCnt    = 6'd42;
  localparam logic [5:0] IdArpCnt    = 6'd43;
  localparam logic [5:0] IdRawCnt    = 6'd44;
  localparam logic [5:0] IdSnapCnt   = 6'd45;

  typedef enum logic [5:0] {
    P_DST, P_SRC, P_TYPE, P_LLC2, P_LLC3, P_OUI, P_ORGT,
    P_IP0, P_TOS, P_LEN, P_ID, P_FRAG, P_TTL, P_PROTO, P_CSUM, P_SIP, P_DIP,
    P_SKIP,
    P_HWT, P_PRT, P_HLEN, P_PLEN, P_OP, P_SHA, P_SPA, P_THA, P_TPA,
    P_BPID, P_BVER, P_BTYPE, P_BFLAGS, P_ROOT, P_COST, P_BRID, P_PORT,
    P_MAGE, P_MAXA, P_HELLO, P_FWD
  } phase_e;

  typedef struct packed {
    logic [5:0]  id;
    logic [63:0] value;
    logic        last;
  } rec_t;

  typedef struct packed {
    rec_t [MaxRecs-1:0] recs;
    logic [RecIdxW-1:0] cnt;
  } batch_t;

  function automatic logic [3:0] phase_len(phase_e ph);
    logic [3:0] len;
    case (ph)
      P_DST, P_SRC:                     len = 4'd6;
      P_ROOT, P_BRID:                   len = 4'd8;
      P_SIP, P_DIP, P_COST:             len = 4'd4;
      P_OUI:                            len = 4'd3;
      P_LLC3, P_IP0, P_TOS, P_TTL, P_PROTO, P_HLEN, P_PLEN,
      P_BVER, P_BTYPE, P_BFLAGS:        len = 4'd1;
      default:                          len = 4'd2;
    endcase
    return len;
  endfunction

  function automatic logic [5:0] phase_id(phase_e ph);
    logic [5:0] id;
    case (ph)
      P_DST:    id = 6'd0;
      P_SRC:    id = 6'd1;
      P_TYPE:   id = 6'd2;
      P_LLC2:   id = 6'd3;
      P_LLC3:   id = 6'd4;
      P_OUI:    id = 6'd5;
      P_ORGT:   id = 6'd6;
      P_IP0:    id = 6'd7;
      P_TOS:    id = 6'd9;
      P_LEN:    id = 6'd10;
      P_ID:     id = 6'd11;
      P_FRAG:   id = 6'd12;
      P_TTL:    id = 6'd14;
      P_PROTO:  id = 6'd15;
      P_CSUM:   id = 6'd16;
      P_SIP:    id = 6'd17;
      P_DIP:    id = 6'd18;
      P_HWT:    id = 6'd19;
      P_PRT:    id = 6'd20;
      P_HLEN:   id = 6'd21;
      P_PLEN:   id = 6'd22;
      P_OP:     id = 6'd23;
      P_SHA:    id = 6'd24;
      P_SPA:    id = 6'd25;
      P_THA:    id = 6'd26;
      P_TPA:    id = 6'd27;
      P_BPID:   id = 6'd28;
      P_BVER:   id = 6'd29;
      P_BTYPE:  id = 6'd30;
      P_BFLAGS: id = 6'd31;
      P_ROOT:   id = 6'd32;
      P_COST:   id = 6'd33;
      P_BRID:   id = 6'd34;
      P_PORT:   id = 6'd35;
      P_MAGE:   id = 6'd36;
      P_MAXA:   id = 6'd37;
      P_HELLO:  id = 6'd38;
      P_FWD:    id = 6'd39;
      default:  id = 6'd0;
    endcase
    return id;
  endfunction

  function automatic rec_t mk_rec(logic [5:0] id, logic [63:0] value);
    rec_t r;
    r.id    = id;
    r.value = value;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

[rtl/ehp_core.sv]
// ehp_core: parse state, class counters and the per-byte step into a record batch
module ehp_core import ehp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  input  logic        req_i,
  input  logic        opcode_i,
  input  logic [7:0]  byte_i,
  output batch_t      batch_o
);

  logic [15:0]           thr_q;
  phase_e                phase_q, phase_d;
  logic [3:0]            bidx_q, bidx_d;
  logic [63:0]           acc_q, acc_d;
  logic                  macnz_q, macnz_d;
  logic [15:0]           skip_q, skip_d;
  logic [15:0]           prefix_q, prefix_d;
  logic [7:0]            hlen_q, hlen_d, plen_q, plen_d;
  logic [CountWidth-1:0] frame_q, frame_d, ipv4_q, ipv4_d, llc_q, llc_d;
  logic [CountWidth-1:0] arp_q, arp_d, raw_q, raw_d, snap_q, snap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThresholdReset;
    end else if (cfg_wr_en_i) begin
      thr_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= P_DST;
      bidx_q   <= '0;
      acc_q    <= '0;
      macnz_q  <= 1'b0;
      skip_q   <= '0;
      prefix_q <= '0;
      hlen_q   <= '0;
      plen_q   <= '0;
      frame_q  <= '0;
      ipv4_q   <= '0;
      llc_q    <= '0;
      arp_q    <= '0;
      raw_q    <= '0;
      snap_q   <= '0;
    end else if (req_i) begin
      phase_q  <= phase_d;
      bidx_q   <= bidx_d;
      acc_q    <= acc_d;
      macnz_q  <= macnz_d;
      skip_q   <= skip_d;
      prefix_q <= prefix_d;
      hlen_q   <= hlen_d;
      plen_q   <= plen_d;
      frame_q  <= frame_d;
      ipv4_q   <= ipv4_d;
      llc_q    <= llc_d;
      arp_q    <= arp_d;
      raw_q    <= raw_d;
      snap_q   <= snap_d;
    end
  end

  always_comb begin
    logic [RecIdxW-1:0] n;
    logic [63:0]        v;
    logic [63:0]        sh;
    logic [15:0]        skp;
    logic               do_arp;
    logic               adv;
    logic               done;
    logic [2:0]         start;
    logic [7:0]         alen;
    phase_e             ph;

    phase_d  = phase_q;
    bidx_d   = bidx_q;
    acc_d    = acc_q;
    macnz_d  = macnz_q;
    skip_d   = skip_q;
    prefix_d = prefix_q;
    hlen_d   = hlen_q;
    plen_d   = plen_q;
    frame_d  = frame_q;
    ipv4_d   = ipv4_q;
    llc_d    = llc_q;
    arp_d    = arp_q;
    raw_d    = raw_q;
    snap_d   = snap_q;
    batch_o  = '0;
    n        = '0;
    v        = '0;
    sh       = {acc_q[55:0], byte_i};
    skp      = '0;
    do_arp   = 1'b0;
    adv      = 1'b1;
    done     = 1'b0;
    start    = '0;
    alen     = '0;
    ph       = phase_q;

    if (opcode_i) begin
      batch_o.recs[0] = mk_rec(IdFrameCnt, 64'(frame_q));
      batch_o.recs[1] = mk_rec(IdIpv4Cnt, 64'(ipv4_q));
      batch_o.recs[2] = mk_rec(IdLlcCnt, 64'(llc_q));
      batch_o.recs[3] = mk_rec(IdArpCnt, 64'(arp_q));
      batch_o.recs[4] = mk_rec(IdRawCnt, 64'(raw_q));
      batch_o.recs[5] = mk_rec(IdSnapCnt, 64'(snap_q));
      batch_o.recs[5].last = 1'b1;
      n = RecIdxW'(MaxRecs);
    end else if (ph == P_SKIP) begin
      skp = (skip_q != '0) ? skip_q - 16'd1 : skip_q;
      skip_d = skp;
      if (skp == '0) begin
        done = 1'b1;
      end
    end else if (ph == P_SHA || ph == P_SPA || ph == P_THA || ph == P_TPA) begin
      acc_d = sh & ArpMask;
      skp = (skip_q != '0) ? skip_q - 16'd1 : skip_q;
      skip_d = skp;
      if (skp == '0) begin
        batch_o.recs[n] = mk_rec(phase_id(ph), sh & ArpMask);
        n = n + 1'b1;
        do_arp = 1'b1;
        start = 3'(ph - P_SHA) + 3'd1;
      end
    end else begin
      if (ph == P_DST && byte_i != 8'd0) begin
        macnz_d = 1'b1;
      end
      acc_d  = sh;
      bidx_d = bidx_q + 4'd1;
      if (bidx_d >= phase_len(ph)) begin
        v       = sh;
        acc_d   = '0;
        bidx_d  = '0;
        phase_d = phase_e'(ph + 6'd1);
        case (ph)
          P_DST: begin
            if (!macnz_d) begin
              done = 1'b1;
            end else begin
              macnz_d = 1'b0;
              if (frame_q != '1) frame_d = frame_q + 1'b1;
              batch_o.recs[n] = mk_rec(IdDst, v);
              n = n + 1'b1;
            end
          end
          P_TYPE: begin
            batch_o.recs[n] = mk_rec(IdType, v);
            n = n + 1'b1;
            if (v[15:0] > thr_q) begin
              if (v[15:0] == TypeIpv4) begin
                if (ipv4_q != '1) ipv4_d = ipv4_q + 1'b1;
                phase_d = P_IP0;
              end else if (v[15:0] == TypeArp) begin
                if (arp_q != '1) arp_d = arp_q + 1'b1;
                phase_d = P_HWT;
              end else begin
                batch_o.recs[0].last = 1'b1;
                done = 1'b1;
              end
            end
          end
          P_LLC2: begin
            prefix_d = v[15:0];
            batch_o.recs[n] = mk_rec(IdLlcPair, v);
            n = n + 1'b1;
            if (v[15:0] == RawPrefix) begin
              if (raw_q != '1) raw_d = raw_q + 1'b1;
              phase_d = P_IP0;
            end
          end
          P_LLC3: begin
            batch_o.recs[n] = mk_rec(IdLlcCtrl, v);
            n = n + 1'b1;
            if (prefix_q == SnapPrefix) begin
              if (snap_q != '1) snap_d = snap_q + 1'b1;
              phase_d = P_OUI;
            end else begin
              if (llc_q != '1) llc_d = llc_q + 1'b1;
              if (prefix_q == IpLlcPrefix) begin
                phase_d = P_IP0;
              end else if (prefix_q == BpduPrefix) begin
                phase_d = P_BPID;
              end else begin
                batch_o.recs[0].last = 1'b1;
                done = 1'b1;
              end
            end
          end
          P_ORGT: begin
            batch_o.recs[n] = mk_rec(IdSnapType, v);
            n = n + 1'b1;
            phase_d = P_IP0;
          end
          P_IP0: begin
            batch_o.recs[0] = mk_rec(IdIpVer, {60'd0, v[7:4]});
            batch_o.recs[1] = mk_rec(IdIpHlen, {60'd0, v[3:0]});
            n = 3'd2;
          end
          P_LEN: begin
            batch_o.recs[n] = mk_rec(IdIpLen, v);
            n = n + 1'b1;
            skip_d = (v[15:0] >= IpHdrBytes) ? v[15:0] - IpHdrBytes : '0;
          end
          P_FRAG: begin
            batch_o.recs[0] = mk_rec(IdIpFlags, {61'd0, v[15:13]});
            batch_o.recs[1] = mk_rec(IdIpFrag, {48'd0, v[15:0] & FragMask});
            n = 3'd2;
          end
          P_DIP: begin
            batch_o.recs[0] = mk_rec(IdIpDst, v);
            batch_o.recs[0].last = 1'b1;
            n = 3'd1;
            if (skip_q != '0) begin
              phase_d = P_SKIP;
            end else begin
              done = 1'b1;
            end
          end
          P_HLEN: begin
            hlen_d = v[7:0];
            batch_o.recs[n] = mk_rec(IdArpHlen, v);
            n = n + 1'b1;
          end
          P_PLEN: begin
            plen_d = v[7:0];
            batch_o.recs[n] = mk_rec(IdArpPlen, v);
            n = n + 1'b1;
          end
          P_OP: begin
            batch_o.recs[n] = mk_rec(IdArpOp, v);
            n = n + 1'b1;
            do_arp = 1'b1;
            start = 3'd0;
          end
          P_FWD: begin
            batch_o.recs[0] = mk_rec(IdFwdDelay, v);
            batch_o.recs[0].last = 1'b1;
            n = 3'd1;
            done = 1'b1;
          end
          default: begin
            batch_o.recs[n] = mk_rec(phase_id(ph), v);
            n = n + 1'b1;
          end
        endcase
      end
    end

    // walk the address phases, a zero length address comes out right away
    if (do_arp) begin
      for (int j = 0; j < 4; j++) begin
        if (adv && 3'(j) >= start) begin
          alen = (j == 0 || j == 2) ? hlen_q : plen_q;
          if (alen != 8'd0) begin
            phase_d = phase_e'(P_SHA + 6'(j));
            skip_d  = 16'(alen);
            acc_d   = '0;
            adv     = 1'b0;
          end else begin
            batch_o.recs[n] = mk_rec(IdArpSha + 6'(j), 64'd0);
            n = n + 1'b1;
          end
        end
      end
      if (adv) begin
        batch_o.recs[n - 1'b1].last = 1'b1;
        done = 1'b1;
      end
    end

    if (done) begin
      phase_d = P_DST;
      bidx_d  = '0;
      acc_d   = '0;
      macnz_d = 1'b0;
      skip_d  = '0;
    end
    batch_o.cnt = n;
  end

endmodule

[rtl/ehp_emit.sv]
// ehp_emit: result register that holds one batch of records and hands them out in order
module ehp_emit import ehp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  batch_t      batch_i,
  output logic        free_o,
  output logic        valid_o,
  input  logic        ready_i,
  output rec_t        rec_o
);

  rec_t [MaxRecs-1:0] recs_q;
  logic [RecIdxW-1:0] cnt_q;
  logic [RecIdxW-1:0] idx_q;
  logic               pop;

  assign valid_o = (idx_q < cnt_q);
  assign pop     = valid_o && ready_i;
  assign rec_o   = recs_q[idx_q];
  // free when empty or the final record leaves this cycle
  assign free_o  = !valid_o || (pop && (idx_q + 1'b1 == cnt_q));

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      recs_q <= batch_i.recs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= batch_i.cnt;
      idx_q <= '0;
    end else if (pop) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) idx_q <= cnt_q)
    else $error("record index beyond batch");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RecIdxW'(MaxRecs))
    else $error("batch count too large");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("batch loaded while records pending");
  a_pop_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !load_i) |=> idx_q == $past(idx_q) + 1'b1)
    else $error("record index did not advance");

endmodule

[rtl/ethernet_header_parser.sv]
// ethernet_header_parser: top level of the byte-wise ethernet header parser
//
// channel  | direction | fields
// s_axis   | in        | tdata: data_byte[7:0]; tuser: opcode
// m_axis   | out       | tdata: field_value[63:0]; tuser: field_id[5:0]; tlast: last
// cfg      | in        | cfg_wr_data_i: type_threshold[15:0]
//
// a request is parsed in the cycle it is taken; its records appear the next cycle
// one byte a cycle sustained while each byte gives at most one record and m_axis_tready stays high
// a byte with more than one record holds off the next request until its final record is taken
// reset clears parse state and counters, threshold back to 0x05FE
// while any record is held, s_axis waits until the cycle the final one is taken
module ethernet_header_parser import ehp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // field_value
  output logic [5:0]  m_axis_tuser,   // field_id
  output logic        m_axis_tlast
);

  logic   req;
  logic   free;
  batch_t batch;
  rec_t   rec;

  assign s_axis_tready = free;
  assign req           = s_axis_tvalid && free;

  ehp_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .req_i         (req),
    .opcode_i      (s_axis_tuser),
    .byte_i        (s_axis_tdata),
    .batch_o       (batch)
  );

  ehp_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (req),
    .batch_i (batch),
    .free_o  (free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .rec_o   (rec)
  );

  assign m_axis_tdata = rec.value;
  assign m_axis_tuser = rec.id;
  assign m_axis_tlast = rec.last;

endmodule
